FILE: src/assert_macros.svh
// Assertion macros for the interpolated table lookup modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define ILUT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define ILUT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILUT_ASSERT(name, clk, rst, prop, msg)
`define ILUT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: src/ilut_pkg.sv
// Shared types and constants of the interpolated table lookup unit.
package ilut_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int LEN_W = 7;
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PADDR_W = 4;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] REG_TABLE_LENGTH = 2'd0;
  localparam logic [1:0] REG_CLAMP_MODE = 2'd1;
  localparam logic [1:0] REG_SNAP_MODE = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic clamp;
    logic snap;
  } cfg_t;

  typedef struct packed {
    logic short_tab;
    logic [FRAC_W-1:0] frac;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } pair_t;

endpackage

FILE: src/interpolated_table_lookup_unit.sv
// Top level of the interpolated table lookup unit.
//
//  channel   | ports                                              | beat taken when
//  ----------+----------------------------------------------------+-------------------------
//  item in   | cmd, entry_index, entry_value, lookup_index        | start && !busy
//  result    | result_value                                       | result_valid (one cycle)
//  config    | psel, penable, pwrite, paddr, pwdata, prdata       | psel && penable && pwrite
//
// One item is taken every cycle; busy stays low. A lookup beat passes five register stages:
// scale multiply, table read, difference, weight multiply, sum.
// A write beat stores its entry at acceptance and gives no result.
// Reset clears the registers and the pipeline valid bits; the table holds no reset value.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module interpolated_table_lookup_unit #(
  parameter int MAX_ENTRIES = ilut_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [5:0]                          entry_index,
  input  logic signed [ilut_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [ilut_pkg::DATA_W-1:0]  lookup_index,
  output logic                                result_valid,
  output logic signed [ilut_pkg::DATA_W-1:0]  result_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ilut_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  ilut_pkg::cfg_t  cfg;
  ilut_pkg::pair_t pair;
  logic            pair_valid;
  logic            take;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign take = start && !busy;

  ilut_regs #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .cfg(cfg)
  );

  ilut_addr #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_addr (
    .clk(clk),
    .rst(rst),
    .take(take),
    .cmd(cmd),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .lookup_index(lookup_index),
    .cfg(cfg),
    .pair_valid(pair_valid),
    .pair(pair)
  );

  ilut_lerp u_lerp (
    .clk(clk),
    .rst(rst),
    .pair_valid(pair_valid),
    .pair(pair),
    .result_valid(result_valid),
    .result_value(result_value)
  );

endmodule

FILE: src/ilut_regs.sv
// Configuration registers behind the APB-style port.
module ilut_regs #(
  parameter int MAX_ENTRIES = ilut_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ilut_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output ilut_pkg::cfg_t               cfg
);

  logic [ilut_pkg::LEN_W-1:0] table_length;
  logic                       clamp_mode;
  logic                       snap_mode;
  logic                       wr_en;
  logic [1:0]                 reg_sel;

  assign wr_en = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
      clamp_mode <= 1'b0;
      snap_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        ilut_pkg::REG_TABLE_LENGTH: table_length <= pwdata[ilut_pkg::LEN_W-1:0];
        ilut_pkg::REG_CLAMP_MODE:   clamp_mode <= pwdata[0];
        ilut_pkg::REG_SNAP_MODE:    snap_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ilut_pkg::REG_TABLE_LENGTH: prdata = {{(32-ilut_pkg::LEN_W){1'b0}}, table_length};
      ilut_pkg::REG_CLAMP_MODE:   prdata = {31'd0, clamp_mode};
      ilut_pkg::REG_SNAP_MODE:    prdata = {31'd0, snap_mode};
      default:                    prdata = 32'd0;
    endcase
  end

  // A length beyond the table depth is used as the depth.
  always_comb begin
    cfg.length = (32'(table_length) > MAX_ENTRIES) ? ilut_pkg::LEN_W'(MAX_ENTRIES)
                                                   : table_length;
    cfg.clamp = clamp_mode;
    cfg.snap = snap_mode;
  end

endmodule

FILE: src/ilut_addr.sv
// Position scaling, slot selection and the sample table (two pipeline stages).
module ilut_addr #(
  parameter int MAX_ENTRIES = ilut_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic                                cmd,
  input  logic [5:0]                          entry_index,
  input  logic signed [ilut_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [ilut_pkg::DATA_W-1:0]  lookup_index,
  input  ilut_pkg::cfg_t                      cfg,
  output logic                                pair_valid,
  output ilut_pkg::pair_t                     pair
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW = ilut_pkg::LEN_W;
  localparam int FW = ilut_pkg::FRAC_W;
  localparam int SW = LW + FW;

  logic signed [ilut_pkg::DATA_W-1:0] sample_table [MAX_ENTRIES];

  // Stage 1: scale the fractional part of the position by the span.
  logic [LW-1:0] mult_by;
  logic [SW-1:0] scaled;
  logic          above_one;
  logic          not_positive;

  logic          v1;
  logic [SW-1:0] s1;
  logic          hi1;
  logic          lo1;
  logic          short1;
  logic          snap1;
  logic [LW-1:0] len1;

  // Only the fraction matters: the integer part either clamps or wraps away.
  assign mult_by = cfg.clamp ? (cfg.length - LW'(1)) : cfg.length;
  assign scaled = {{LW{1'b0}}, lookup_index[FW-1:0]} * {{FW{1'b0}}, mult_by};
  assign above_one = !lookup_index[31] && (lookup_index[30:FW] != '0);
  assign not_positive = lookup_index[31] || (lookup_index == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take && (cmd == ilut_pkg::CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    s1 <= scaled;
    hi1 <= cfg.clamp && above_one;
    lo1 <= cfg.clamp && not_positive;
    short1 <= (cfg.length < LW'(2));
    snap1 <= cfg.snap;
    len1 <= cfg.length;
  end

  // Stage 2: pick the two slots and read them.
  logic [LW-1:0] slot_lo;
  logic [LW-1:0] slot_inc;
  logic [LW-1:0] rd_i;
  logic [LW-1:0] rd_n;
  logic [FW-1:0] frac;

  assign slot_lo = s1[SW-1:FW];
  assign slot_inc = slot_lo + LW'(1);

  // Pinned ends read one entry with a zero fraction, which returns it unchanged.
  always_comb begin
    if (hi1) begin
      rd_i = len1 - LW'(1);
      rd_n = rd_i;
      frac = '0;
    end else if (lo1) begin
      rd_i = '0;
      rd_n = '0;
      frac = '0;
    end else begin
      rd_i = slot_lo;
      rd_n = (slot_inc >= len1) ? '0 : slot_inc;
      frac = snap1 ? '0 : s1[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      pair_valid <= v1;
    end
  end

  // Writes land at accept; a lookup accepted after the write already sees them.
  always_ff @(posedge clk) begin
    if (take && (cmd == ilut_pkg::CMD_WRITE) && (32'(entry_index) < MAX_ENTRIES)) begin
      sample_table[AW'(entry_index)] <= entry_value;
    end
    pair.a <= sample_table[AW'(rd_i)];
    pair.b <= sample_table[AW'(rd_n)];
    pair.frac <= frac;
    pair.short_tab <= short1;
  end

endmodule

FILE: src/ilut_lerp.sv
// Linear interpolation between two samples (three pipeline stages).
`include "assert_macros.svh"
module ilut_lerp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pair_valid,
  input  ilut_pkg::pair_t                    pair,
  output logic                               result_valid,
  output logic signed [ilut_pkg::DATA_W-1:0] result_value
);

  localparam int DW = ilut_pkg::DATA_W;
  localparam int FW = ilut_pkg::FRAC_W;
  localparam int PW = DW + 1 + FW + 1;

  // Stage 3: difference of the two samples.
  logic                 v3;
  logic signed [DW:0]   diff3;
  logic signed [DW-1:0] a3;
  logic [FW-1:0]        f3;
  logic                 short3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff3 <= {pair.b[DW-1], pair.b} - {pair.a[DW-1], pair.a};
    a3 <= pair.a;
    f3 <= pair.frac;
    short3 <= pair.short_tab;
  end

  // Stage 4: weight the difference by the fraction.
  logic                 v4;
  logic signed [PW-1:0] prod4;
  logic signed [DW-1:0] a4;
  logic                 short4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod4 <= PW'(diff3 * $signed({1'b0, f3}));
    a4 <= a3;
    short4 <= short3;
  end

  // Stage 5: dropping the low bits of a signed product floors it.
  logic signed [PW-FW-1:0] sum5;

  assign sum5 = {{(PW-FW-DW){a4[DW-1]}}, a4} + prod4[PW-1:FW];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    result_value <= short4 ? ilut_pkg::ONE_Q16 : sum5[DW-1:0];
  end

  `ILUT_ASSERT(a_stage_advance, clk, rst, v3 |=> v4, "pipeline lost a lookup")
  `ILUT_ASSERT(a_result_source, clk, rst, result_valid |-> $past(v4), "result without lookup")
  `ILUT_ASSERT_ALWAYS(a_reset_flush, clk, rst |=> (!result_valid && !v4 && !v3),
                      "pipeline not flushed by reset")

endmodule
